>>> rtl/gsm_pkg.sv
package gsm_pkg;

    localparam int unsigned CNT_W              = 10;
    localparam int unsigned MAX_ITERATIONS_DEF = 1000;
    localparam int unsigned TOL_W              = 31;
    localparam int unsigned PT_W               = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    // 2 - phi as a q0.32 fraction
    localparam logic [30:0] RESPHI_Q32 = 31'd1640531527;

    typedef logic [1:0] slot_t;

    localparam slot_t SLOT_A = 2'd0;
    localparam slot_t SLOT_B = 2'd1;
    localparam slot_t SLOT_C = 2'd2;
    localparam slot_t SLOT_X = 2'd3;

    typedef enum logic
    {
        ACT_START = 1'b0,
        ACT_REPLY = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        KIND_EVAL   = 2'd0,
        KIND_ANSWER = 2'd1,
        KIND_FLAT   = 2'd2,
        KIND_LIMIT  = 2'd3
    } kind_t;

    typedef struct packed
    {
        action_t                action;
        logic signed [PT_W-1:0] lower_bound;
        logic signed [PT_W-1:0] upper_bound;
        logic signed [PT_W-1:0] function_value;
    } cmd_t;

    typedef struct packed
    {
        kind_t                  kind;
        logic signed [PT_W-1:0] point;
    } rsp_t;

    typedef struct packed
    {
        logic                       busy;
        logic [CNT_W-1:0]           iteration_count;
        slot_t                      pending_point;
        logic [3:0]                 value_valid;
        logic [3:0][PT_W-1:0]       known_values;
        logic signed [PT_W-1:0]     point_a;
        logic signed [PT_W-1:0]     point_b;
        logic signed [PT_W-1:0]     point_c;
        logic signed [PT_W-1:0]     point_x;
    } gsm_state_t;

endpackage

>>> rtl/gsm_golden.sv
module gsm_golden
    import gsm_pkg::*;
(
    input  logic signed [PT_W:0]   diff,
    output logic signed [PT_W-1:0] part
);

    logic [PT_W:0]     mag;
    logic [2*PT_W-1:0] prod;
    logic [2*PT_W-1:0] rounded;
    logic [PT_W-1:0]   part_mag;

    // round to nearest in magnitude, ties away from zero
    assign mag      = diff[PT_W] ? (PT_W+1)'(-diff) : (PT_W+1)'(diff);
    assign prod     = {{(PT_W-1){1'b0}}, mag} * {{(PT_W+1){1'b0}}, RESPHI_Q32};
    assign rounded  = prod + {{PT_W{1'b0}}, 1'b1, {(PT_W-1){1'b0}}};
    assign part_mag = rounded[2*PT_W-1:PT_W];
    assign part     = diff[PT_W] ? $signed(-part_mag) : $signed(part_mag);

endmodule

>>> rtl/gsm_step.sv
module gsm_step
    import gsm_pkg::*;
#(
    parameter int unsigned MAX_ITERATIONS = MAX_ITERATIONS_DEF
)
(
    input  gsm_state_t       st,
    input  cmd_t             cmd,
    input  logic [TOL_W-1:0] tolerance,
    output gsm_state_t       st_next,
    output logic             emit,
    output rsp_t             rsp
);

    gsm_state_t             adv;
    logic                   go;
    logic                   adv_emit;
    rsp_t                   adv_rsp;

    logic [CNT_W-1:0]       cnt_new;
    logic signed [PT_W:0]   width;
    logic [PT_W:0]          width_abs;
    logic signed [PT_W:0]   sum_ac;
    logic signed [PT_W+1:0] d_right;
    logic signed [PT_W+1:0] d_left;
    logic                   right_long;
    logic signed [PT_W:0]   golden_diff;
    logic signed [PT_W-1:0] golden_part;
    logic signed [PT_W-1:0] x_new;

    // start, or store the reply, ask for a missing value, or move bracket
    always_comb
    begin
        logic [3:0][PT_W-1:0]   kv;
        logic [3:0]             vv;
        logic [3:0][PT_W-1:0]   pts;
        logic signed [PT_W:0]   sum_lh;
        logic signed [PT_W+1:0] dcb;
        logic signed [PT_W+1:0] dba;
        logic                   rl;
        logic                   xlt;
        logic                   x_eq_b;
        slot_t                  sa;
        slot_t                  sb;
        slot_t                  sc;

        adv      = st;
        go       = 1'b0;
        adv_emit = 1'b0;
        adv_rsp  = '{kind: KIND_EVAL, point: '0};
        kv       = st.known_values;
        vv       = st.value_valid;
        pts      = '0;
        sa       = SLOT_A;
        sb       = SLOT_B;
        sc       = SLOT_C;
        sum_lh   = {cmd.lower_bound[PT_W-1], cmd.lower_bound}
                 + {cmd.upper_bound[PT_W-1], cmd.upper_bound};
        dcb      = {{2{st.point_c[PT_W-1]}}, st.point_c} - {{2{st.point_b[PT_W-1]}}, st.point_b};
        dba      = {{2{st.point_b[PT_W-1]}}, st.point_b} - {{2{st.point_a[PT_W-1]}}, st.point_a};
        rl       = dcb > dba;
        xlt      = 1'b0;
        x_eq_b   = 1'b0;

        if (cmd.action == ACT_START)
        begin
            adv.point_a         = cmd.lower_bound;
            adv.point_c         = cmd.upper_bound;
            adv.point_b         = sum_lh[PT_W:1];
            adv.point_x         = '0;
            adv.value_valid     = '0;
            adv.pending_point   = SLOT_A;
            adv.iteration_count = '0;
            adv.busy            = 1'b1;
            go                  = 1'b1;
        end
        else if (st.busy)
        begin
            kv[st.pending_point] = cmd.function_value;
            vv                   = st.value_valid | (4'b0001 << st.pending_point);
            adv.known_values     = kv;
            adv.value_valid      = vv;
            x_eq_b               = kv[SLOT_X] == kv[SLOT_B];
            xlt                  = $signed(kv[SLOT_X]) < $signed(kv[SLOT_B]);

            if (!vv[SLOT_X])
            begin
                adv.pending_point = SLOT_X;
                adv_emit          = 1'b1;
                adv_rsp           = '{kind: KIND_EVAL, point: st.point_x};
            end
            else if (!vv[SLOT_B])
            begin
                adv.pending_point = SLOT_B;
                adv_emit          = 1'b1;
                adv_rsp           = '{kind: KIND_EVAL, point: st.point_b};
            end
            else if (x_eq_b && !vv[SLOT_A])
            begin
                adv.pending_point = SLOT_A;
                adv_emit          = 1'b1;
                adv_rsp           = '{kind: KIND_EVAL, point: st.point_a};
            end
            else if (x_eq_b && !vv[SLOT_C])
            begin
                adv.pending_point = SLOT_C;
                adv_emit          = 1'b1;
                adv_rsp           = '{kind: KIND_EVAL, point: st.point_c};
            end
            else if (x_eq_b && kv[SLOT_A] == kv[SLOT_C] && kv[SLOT_A] == kv[SLOT_B])
            begin
                adv.busy = 1'b0;
                adv_emit = 1'b1;
                adv_rsp  = '{kind: KIND_FLAT, point: '0};
            end
            else
            begin
                if (xlt)
                begin
                    sa = rl ? SLOT_B : SLOT_A;
                    sb = SLOT_X;
                    sc = rl ? SLOT_C : SLOT_B;
                end
                else
                begin
                    sa = rl ? SLOT_A : SLOT_X;
                    sb = SLOT_B;
                    sc = rl ? SLOT_X : SLOT_C;
                end
                pts[SLOT_A] = st.point_a;
                pts[SLOT_B] = st.point_b;
                pts[SLOT_C] = st.point_c;
                pts[SLOT_X] = st.point_x;
                adv.point_a = pts[sa];
                adv.point_b = pts[sb];
                adv.point_c = pts[sc];
                adv.known_values[SLOT_A] = kv[sa];
                adv.known_values[SLOT_B] = kv[sb];
                adv.known_values[SLOT_C] = kv[sc];
                adv.value_valid[SLOT_A]  = vv[sa];
                adv.value_valid[SLOT_B]  = vv[sb];
                adv.value_valid[SLOT_C]  = vv[sc];
                adv.value_valid[SLOT_X]  = 1'b0;
                go = 1'b1;
            end
        end
    end

    // new search step on the bracket left by the first half
    assign cnt_new   = adv.iteration_count + 1'b1;
    assign width     = {adv.point_c[PT_W-1], adv.point_c} - {adv.point_a[PT_W-1], adv.point_a};
    assign width_abs = width[PT_W] ? (PT_W+1)'(-width) : (PT_W+1)'(width);
    assign sum_ac    = {adv.point_a[PT_W-1], adv.point_a} + {adv.point_c[PT_W-1], adv.point_c};
    assign d_right   = {{2{adv.point_c[PT_W-1]}}, adv.point_c}
                     - {{2{adv.point_b[PT_W-1]}}, adv.point_b};
    assign d_left    = {{2{adv.point_b[PT_W-1]}}, adv.point_b}
                     - {{2{adv.point_a[PT_W-1]}}, adv.point_a};
    assign right_long  = d_right > d_left;
    // b - g(b - a) equals b + g(a - b), since the rounding is symmetric
    assign golden_diff = right_long ? d_right[PT_W:0] : (PT_W+1)'(-d_left);
    assign x_new       = adv.point_b + golden_part;

    gsm_golden u_golden
    (
        .diff (golden_diff),
        .part (golden_part)
    );

    always_comb
    begin
        st_next = adv;
        emit    = adv_emit;
        rsp     = adv_rsp;
        if (go)
        begin
            st_next.iteration_count = cnt_new;
            emit                    = 1'b1;
            if (cnt_new >= CNT_W'(MAX_ITERATIONS))
            begin
                st_next.busy = 1'b0;
                rsp          = '{kind: KIND_LIMIT, point: '0};
            end
            else if (width_abs < {2'b00, tolerance})
            begin
                st_next.busy = 1'b0;
                rsp          = '{kind: KIND_ANSWER, point: sum_ac[PT_W:1]};
            end
            else
            begin
                st_next.point_x             = x_new;
                st_next.value_valid[SLOT_X] = 1'b0;
                st_next.pending_point       = SLOT_X;
                rsp                         = '{kind: KIND_EVAL, point: x_new};
            end
        end
    end

endmodule

>>> rtl/golden_section_minimizer.sv
// golden section minimizer, q16.16 fixed point
// flow: a taken command item waits in the input register, runs through the step logic
//   once the result register is free or drained, and its result item is registered there
// throughput: one command item per cycle unless stalled; the state loop (bracket
//   select, golden multiply, add) is combinational, so replies go back to back
// reset: rst_n asynchronous active low; idle, empty pipeline, tolerance = 66
module golden_section_minimizer
    import gsm_pkg::*;
#(
    parameter int unsigned MAX_ITERATIONS = MAX_ITERATIONS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  cmd_t             cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp,
    input  logic             tol_write,
    input  logic [TOL_W-1:0] tol_data
);

    // input register: one command item waiting for the step logic
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic             cmd_full_reg;
    logic             cmd_full_next;

    // search state: bracket points, learned values, count, busy flag
    gsm_state_t       state_reg;
    gsm_state_t       state_next;

    // result register, parts the two sides
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    logic [TOL_W-1:0] tol_reg;
    logic [TOL_W-1:0] tol_next;

    gsm_state_t       step_state;
    logic             step_emit;
    rsp_t             step_rsp;

    logic             fire;
    logic             accept;

    // the held item runs when the result register is free or being drained
    assign fire      = cmd_full_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = cmd_full_reg && !fire;
    assign accept    = cmd_valid && !cmd_stall;

    gsm_step
    #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    )
    u_step
    (
        .st        (state_reg),
        .cmd       (cmd_reg),
        .tolerance (tol_reg),
        .st_next   (step_state),
        .emit      (step_emit),
        .rsp       (step_rsp)
    );

    always_comb
    begin
        cmd_next       = accept ? cmd : cmd_reg;
        cmd_full_next  = accept ? 1'b1 : (fire ? 1'b0 : cmd_full_reg);
        state_next     = fire ? step_state : state_reg;
        tol_next       = tol_write ? tol_data : tol_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (fire)
        begin
            // a reply while idle produces no item
            rsp_valid_next = step_emit;
            if (step_emit)
            begin
                rsp_next = step_rsp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_full_reg  <= 1'b0;
            state_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
        end
        else
        begin
            cmd_full_reg  <= cmd_full_next;
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            tol_reg       <= tol_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> test/tb_golden_section_minimizer.sv
module tb_golden_section_minimizer;
    import gsm_pkg::*;

    // the search gives up after this many steps
    localparam int MAX_STEPS = 1000;
    // 2 - phi as a q0.32 fraction, rounded
    localparam bit [63:0] GOLDEN_Q32 = 64'd1640531527;
    // run guard in clock cycles
    localparam int LIMIT_CYCLES = 1000000;
    // quiet cycles after the last result, covers the input and result registers
    localparam int SETTLE_CYCLES = 8;

    // shapes of the function that the bench plays back to the block
    typedef enum
    {
        SHAPE_VALLEY,
        SHAPE_STEPS,
        SHAPE_LEVEL,
        SHAPE_NOISE,
        SHAPE_PEAK
    } shape_t;

    // tracks the search the block should be running and the result items it owes
    class search_scoreboard;
        bit [TOL_W-1:0] tol;
        longint         pa, pb, pc, px;
        longint         kv[4];
        bit [3:0]       vv;
        slot_t          pend;
        int unsigned    steps;
        bit             busy;
        longint         asked;
        rsp_t           owed[$];
        int             fails;
        int             checked;
        int             seen[4];

        function new();
            tol = TOL_RESET;
            pa = 0;
            pb = 0;
            pc = 0;
            px = 0;
            vv = '0;
            pend = SLOT_A;
            steps = 0;
            busy = 1'b0;
            asked = 0;
            fails = 0;
            checked = 0;
            foreach (seen[i])
                seen[i] = 0;
        endfunction

        function void owe(kind_t k, longint p);
            rsp_t r;
            r.kind = k;
            r.point = p[31:0];
            owed.push_back(r);
        endfunction

        function void ask(slot_t s, longint p);
            pend = s;
            asked = p;
            owe(KIND_EVAL, p);
        endfunction

        // rounded to nearest, ties away from zero, on the magnitude
        function longint golden_part(longint d);
            bit [63:0] mag;
            bit [63:0] prod;
            mag = (d < 0) ? -d : d;
            prod = (mag * GOLDEN_Q32 + 64'h8000_0000) >> 32;
            return (d < 0) ? -longint'(prod) : longint'(prod);
        endfunction

        // one search step: limit, width test, then the next probe point
        function void next_probe();
            longint w;
            steps = (steps + 1) % 1024;
            if (steps >= MAX_STEPS)
            begin
                busy = 1'b0;
                owe(KIND_LIMIT, 0);
                return;
            end
            w = pc - pa;
            if (w < 0)
                w = -w;
            if (w < longint'(tol))
            begin
                busy = 1'b0;
                owe(KIND_ANSWER, (pa + pc) >>> 1);
                return;
            end
            if (pc - pb > pb - pa)
                px = pb + golden_part(pc - pb);
            else
                px = pb - golden_part(pb - pa);
            px = longint'(signed'(px[31:0]));
            vv[SLOT_X] = 1'b0;
            ask(SLOT_X, px);
        endfunction

        // ask for a missing value, stop on a flat function, or narrow the bracket and step on
        function void golden_step();
            longint pts[4];
            longint na, nb, nc, ka, kb, kc;
            slot_t  sa, sb, sc;
            bit     right_long;
            bit [3:0] nv;
            right_long = (pc - pb) > (pb - pa);
            if (!vv[SLOT_X])
            begin
                ask(SLOT_X, px);
                return;
            end
            if (!vv[SLOT_B])
            begin
                ask(SLOT_B, pb);
                return;
            end
            if (kv[SLOT_X] == kv[SLOT_B])
            begin
                if (!vv[SLOT_A])
                begin
                    ask(SLOT_A, pa);
                    return;
                end
                if (!vv[SLOT_C])
                begin
                    ask(SLOT_C, pc);
                    return;
                end
                if (kv[SLOT_A] == kv[SLOT_C] && kv[SLOT_A] == kv[SLOT_B])
                begin
                    busy = 1'b0;
                    owe(KIND_FLAT, 0);
                    return;
                end
            end
            if (kv[SLOT_X] < kv[SLOT_B])
            begin
                if (right_long)
                begin
                    sa = SLOT_B; sb = SLOT_X; sc = SLOT_C;
                end
                else
                begin
                    sa = SLOT_A; sb = SLOT_X; sc = SLOT_B;
                end
            end
            else
            begin
                if (right_long)
                begin
                    sa = SLOT_A; sb = SLOT_B; sc = SLOT_X;
                end
                else
                begin
                    sa = SLOT_X; sb = SLOT_B; sc = SLOT_C;
                end
            end
            pts[SLOT_A] = pa;
            pts[SLOT_B] = pb;
            pts[SLOT_C] = pc;
            pts[SLOT_X] = px;
            na = pts[sa];
            nb = pts[sb];
            nc = pts[sc];
            ka = kv[sa];
            kb = kv[sb];
            kc = kv[sc];
            nv = '0;
            nv[SLOT_A] = vv[sa];
            nv[SLOT_B] = vv[sb];
            nv[SLOT_C] = vv[sc];
            pa = na;
            pb = nb;
            pc = nc;
            kv[SLOT_A] = ka;
            kv[SLOT_B] = kb;
            kv[SLOT_C] = kc;
            vv = nv;
            next_probe();
        endfunction

        function void note_command(cmd_t c);
            if (c.action == ACT_START)
            begin
                pa = longint'(signed'(c.lower_bound));
                pc = longint'(signed'(c.upper_bound));
                pb = (pa + pc) >>> 1;
                px = 0;
                vv = '0;
                pend = SLOT_A;
                steps = 0;
                busy = 1'b1;
                next_probe();
            end
            else if (busy)
            begin
                kv[pend] = longint'(signed'(c.function_value));
                vv[pend] = 1'b1;
                golden_step();
            end
        endfunction

        function void check_result(rsp_t r);
            rsp_t e;
            checked++;
            if (owed.size() == 0)
            begin
                $error("unexpected result item: kind %0d point %0d", r.kind, r.point);
                fails++;
                return;
            end
            e = owed.pop_front();
            seen[e.kind]++;
            if (r.kind !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, r.kind);
                fails++;
            end
            if (r.point !== e.point)
            begin
                $error("point: expected %0d, actual %0d", e.point, r.point);
                fails++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_stall;
    cmd_t             cmd;
    logic             rsp_valid;
    logic             rsp_stall;
    rsp_t             rsp;
    logic             tol_write;
    logic [TOL_W-1:0] tol_data;

    search_scoreboard sb;

    // pacing knobs, in percent per cycle
    int send_idle;
    int stall_pct;
    // long receiver hold-off, counted down by the receiver process
    int hold_left;

    int unsigned cycles;
    int          n_items;
    int          n_tol;

    // the function being minimized in the current search
    shape_t      shape;
    longint      center;
    int          shift;
    bit [31:0]   level;

    golden_section_minimizer #(
        .MAX_ITERATIONS(MAX_STEPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .tol_write(tol_write),
        .tol_data(tol_data)
    );

    always #5 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall, or a forced hold-off while hold_left runs down
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // outputs are stable by the falling edge; the item is taken at the next rise
    always @(negedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // saturating magnitude, so the played-back values stay in 32 bits
    function automatic bit [31:0] clamp_mag(longint d);
        if (d < 0)
            d = -d;
        if (d > 64'sh7FFF_FFFF)
            d = 64'sh7FFF_FFFF;
        return d[31:0];
    endfunction

    // value of the current function at a requested point
    function automatic bit [31:0] value_at(longint x);
        bit [31:0] v;
        case (shape)
            SHAPE_VALLEY: v = clamp_mag(x - center);
            SHAPE_STEPS:  v = clamp_mag(x - center) >> shift;
            SHAPE_LEVEL:  v = level;
            SHAPE_PEAK:   v = -clamp_mag(x - center);
            default:      v = $urandom;
        endcase
        return v;
    endfunction

    // sender pause after an accepted item, geometric length
    task automatic idle_gap();
        int n;
        n = 0;
        while (n < 200 && $urandom_range(99) < send_idle)
            n++;
        if (n > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // offer one item and hold it until the block takes it
    task automatic send_item(input cmd_t c);
        cmd <= c;
        cmd_valid <= 1'b1;
        @(negedge clk);
        while (cmd_stall)
            @(negedge clk);
        @(posedge clk);
        sb.note_command(c);
        n_items++;
        idle_gap();
    endtask

    task automatic send_raw(input action_t act, input bit [31:0] lo, input bit [31:0] hi,
                            input bit [31:0] fv);
        cmd_t c;
        c.action = act;
        c.lower_bound = lo;
        c.upper_bound = hi;
        c.function_value = fv;
        send_item(c);
    endtask

    // answer the point the block is asking about; bracket fields carry junk
    task automatic reply();
        send_raw(ACT_REPLY, $urandom, $urandom, value_at(sb.asked));
    endtask

    // new bracket and new function; noisy forces fully random bracket bounds and random values
    task automatic start_search(input bit noisy);
        int        r;
        bit [31:0] lo, hi;
        longint    slo, shi;
        r = $urandom_range(99);
        lo = $urandom;
        if (noisy || r < 30)
            hi = $urandom;
        else if (r < 80)
            hi = lo + $urandom_range(32'h0100_0000);
        else if (r < 92)
            hi = lo + $urandom_range(140);
        else
            hi = lo;
        slo = longint'(signed'(lo));
        shi = longint'(signed'(hi));
        center = slo + ((shi - slo) * longint'($urandom_range(1000))) / 1000;
        shift = $urandom_range(24, 4);
        level = $urandom;
        r = $urandom_range(99);
        if (noisy)
            shape = SHAPE_NOISE;
        else if (r < 55)
            shape = SHAPE_VALLEY;
        else if (r < 75)
            shape = SHAPE_STEPS;
        else if (r < 83)
            shape = SHAPE_LEVEL;
        else if (r < 93)
            shape = SHAPE_NOISE;
        else
            shape = SHAPE_PEAK;
        send_raw(ACT_START, lo, hi, $urandom);
    endtask

    // mostly complete dialogues, with some restarts and stray replies mixed in
    task automatic run_searches(input int n);
        int done;
        done = 0;
        while (done < n)
        begin
            if (!sb.busy)
            begin
                if ($urandom_range(99) < 4)
                begin
                    send_raw(ACT_REPLY, $urandom, $urandom, $urandom);
                end
                else
                begin
                    start_search(1'b0);
                    done++;
                end
            end
            else if ($urandom_range(99) < 3)
            begin
                start_search(1'b0);
                done++;
            end
            else
            begin
                reply();
                done++;
            end
        end
    endtask

    // play the running search to its end
    task automatic finish_search();
        while (sb.busy)
            reply();
    endtask

    // stop offering and wait for every owed result, then let the pipe settle
    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tol(input bit [TOL_W-1:0] v);
        tol_write <= 1'b1;
        tol_data <= v;
        sb.tol = v;
        n_tol++;
        @(posedge clk);
        tol_write <= 1'b0;
    endtask

    // one phase: new tolerance, pacing, searches, then quiet
    task automatic run_phase(input bit [TOL_W-1:0] tol, input int idle_p, input int stall_p,
                             input int n, input bit hold);
        write_tol(tol);
        send_idle = idle_p;
        stall_pct = stall_p;
        if (hold)
        begin
            // receiver blocks long enough for the block to back up its input
            @(negedge clk);
            hold_left = 300;
            @(posedge clk);
        end
        run_searches(n);
        finish_search();
        drain();
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        rsp_stall = 1'b0;
        tol_write = 1'b0;
        tol_data = '0;
        send_idle = 0;
        stall_pct = 0;
        hold_left = 0;
        cycles = 0;
        n_items = 0;
        n_tol = 0;
        shape = SHAPE_VALLEY;
        center = 0;
        shift = 8;
        level = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, tolerance still at its reset value
        // replies while idle are ignored
        send_raw(ACT_REPLY, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_raw(ACT_REPLY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        // widest bracket, valley at zero
        send_raw(ACT_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        repeat (3) reply();
        // extreme function values while busy
        send_raw(ACT_REPLY, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_raw(ACT_REPLY, 32'h0, 32'h0, 32'h8000_0000);
        // reversed bracket dropped onto a running search
        send_raw(ACT_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        repeat (2) reply();
        // zero width, then widths either side of the tolerance
        send_raw(ACT_START, 32'h0012_0000, 32'h0012_0000, 32'hFFFF_FFFF);
        send_raw(ACT_START, 32'h0, 32'd65, 32'h0);
        send_raw(ACT_START, 32'h0, 32'd66, 32'h0);
        // flat function: equal at x, b, a and c
        shape = SHAPE_LEVEL;
        level = 32'h0003_0000;
        send_raw(ACT_START, 32'hFFF6_0000, 32'h000A_0000, 32'h0);
        finish_search();
        drain();

        // random part: tolerance, sender idle, receiver stall, search items, hold-off
        run_phase(TOL_RESET, 0, 0, 160, 1'b1);
        run_phase(TOL_W'($urandom_range(32'h0010_0000, 1)), 86, 0, 150, 1'b0);
        run_phase(31'd1, 0, 86, 150, 1'b0);
        run_phase(31'h7FFF_FFFF, 11, 11, 80, 1'b0);
        run_phase(TOL_W'($urandom), 11, 11, 110, 1'b0);

        // zero tolerance: the width test never passes, so noise runs into the limit
        write_tol(31'd0);
        send_idle = 0;
        stall_pct = 11;
        start_search(1'b1);
        finish_search();
        drain();

        $display("searched with %0d command items over %0d tolerance settings, among them 0, 1, 66 and max",
                 n_items, n_tol);
        $display("checked %0d results: %0d eval, %0d answer, %0d flat, %0d limit",
                 sb.checked, sb.seen[KIND_EVAL], sb.seen[KIND_ANSWER], sb.seen[KIND_FLAT],
                 sb.seen[KIND_LIMIT]);
        if (sb.fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
